// ===== src/tbbs_pkg.sv =====
package tbbs_pkg;

    // Default sizes handed to the top level.
    localparam int MAX_CITY_COUNT_DEF = 16;
    localparam int DIST_BITS_DEF      = 16;

    // Tour costs are kept in 20 bits and saturate at all ones.
    localparam int COST_BITS       = 20;
    localparam int CITY_COUNT_BITS = 5;
    localparam logic [CITY_COUNT_BITS-1:0] CITY_COUNT_RESET = 5'd16;

    typedef logic [COST_BITS-1:0] cost_t;

    localparam cost_t COST_ALL_ONES = '1;

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        OP_WRITE_DIST = 2'd0,
        OP_APPEND     = 2'd1,
        OP_START      = 2'd2
    } op_t;

    // Result of the shared cost unit: saturated sum and bound compare.
    typedef struct packed {
        cost_t cost;
        logic  below;
    } cost_res_t;

endpackage

// ===== src/tbbs_ram.sv =====
module tbbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/tbbs_cost_unit.sv =====
module tbbs_cost_unit
    import tbbs_pkg::*;
#(
    parameter int DIST_BITS = DIST_BITS_DEF
) (
    input  cost_t                base,
    input  logic [DIST_BITS-1:0] edge_dist,
    input  logic                 zero,
    input  cost_t                bound,
    output cost_res_t            res
);

    localparam int SUM_W = ((DIST_BITS > COST_BITS) ? DIST_BITS : COST_BITS) + 1;

    logic [SUM_W-1:0] sum;
    cost_t            sat;

    // Saturating add of one edge to a partial cost (forced to zero when zero is set), then the bound compare.
    always_comb
    begin
        sum = SUM_W'(base) + SUM_W'(edge_dist);
        if (zero)
        begin
            sat = '0;
        end
        else if (sum > SUM_W'(COST_ALL_ONES))
        begin
            sat = COST_ALL_ONES;
        end
        else
        begin
            sat = sum[COST_BITS-1:0];
        end
        res.cost  = sat;
        res.below = (sat < bound);
    end

endmodule

// ===== src/tour_branch_and_bound_search.sv =====
// Channel  Direction  Handshake             Beat contents
// in       input      in_valid / in_stall   op, row_city, col_city, distance_value,
//                                           prefix_city, start_bound
// out      output     out_valid / out_stall found, tour_distance, position, tour_city, last
// cfg      input      cfg_we                cfg_wdata (city count)
//
// A start beat checks the prefix city by city in S_PRE, adding the edge to each further
// city in S_PRE_ADD, and ends with a closing step in S_PRE.
// The search handles each candidate or backtrack in S_SCAN and each unvisited candidate
// once more in S_ADD (distance RAM read, then shared add and compare); unpruned it scans n
// candidates at each of about e * n! tree nodes.
// n result beats follow, or one when nothing better is found, one per cycle unless stalled.
// Reset clears control state, the prefix length and sets the best bound to all ones.
// in_stall is high from a start beat until its last result beat is taken.
module tour_branch_and_bound_search
    import tbbs_pkg::*;
#(
    parameter int MAX_CITY_COUNT = MAX_CITY_COUNT_DEF,
    parameter int DIST_BITS      = DIST_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CITY_COUNT_BITS-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 op,
    input  logic [3:0]                 row_city,
    input  logic [3:0]                 col_city,
    input  logic [15:0]                distance_value,
    input  logic [3:0]                 prefix_city,
    input  logic [COST_BITS-1:0]       start_bound,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic [COST_BITS-1:0]       tour_distance,
    output logic [3:0]                 position,
    output logic [3:0]                 tour_city,
    output logic                       last
);

    localparam int CIDX  = $clog2(MAX_CITY_COUNT);
    localparam int NW    = $clog2(MAX_CITY_COUNT + 1);
    localparam int AW    = 2 * CIDX;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_PRE_ADD,
        S_SCAN,
        S_ADD,
        S_EMIT
    } state_t;

    state_t                     state_reg;
    logic [CITY_COUNT_BITS-1:0] city_count_reg;
    logic [NW-1:0]              n_reg;
    logic [NW-1:0]              plen_reg;
    logic [3:0]                 prefix_reg    [MAX_CITY_COUNT];
    logic [CIDX-1:0]            wp_reg        [MAX_CITY_COUNT];
    logic [NW-1:0]              nc_reg        [MAX_CITY_COUNT];
    cost_t                      pc_reg        [MAX_CITY_COUNT];
    logic [CIDX-1:0]            best_tour_reg [MAX_CITY_COUNT];
    logic [MAX_CITY_COUNT-1:0]  visited_reg;
    cost_t                      best_reg;
    cost_t                      cost_reg;
    logic                       found_reg;
    logic [NW-1:0]              idx_reg;
    logic [CIDX-1:0]            d_reg;
    logic [CIDX-1:0]            cand_reg;
    logic [CIDX-1:0]            prev_reg;

    logic                 in_fire;
    logic                 out_fire;
    logic [NW-1:0]        n_calc;
    logic [3:0]           pre_city;
    logic [CIDX-1:0]      pre_c;
    logic                 pre_bad;
    logic [NW-1:0]        scan_c;
    logic [CIDX-1:0]      scan_ci;
    logic                 scan_end;
    logic [CIDX-1:0]      prev_city;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [AW-1:0]        ram_raddr;
    logic [DIST_BITS-1:0] ram_rdata;
    cost_t                cu_base;
    logic                 cu_zero;
    cost_res_t            cu_res;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = (state_reg == S_EMIT);
    assign out_fire  = out_valid && !out_stall;

    // City count saturated to the supported range.
    always_comb
    begin
        if (city_count_reg < CITY_COUNT_BITS'(2))
        begin
            n_calc = NW'(2);
        end
        else if (int'(city_count_reg) > MAX_CITY_COUNT)
        begin
            n_calc = NW'(MAX_CITY_COUNT);
        end
        else
        begin
            n_calc = NW'(city_count_reg);
        end
    end

    // Prefix check: city in range and not yet used.
    assign pre_city = prefix_reg[idx_reg[CIDX-1:0]];
    assign pre_c    = CIDX'(pre_city);
    assign pre_bad  = (int'(pre_city) >= int'(n_reg)) || visited_reg[pre_c];

    // Search step: next candidate at the current depth and the city before it.
    assign scan_c    = nc_reg[d_reg];
    assign scan_ci   = CIDX'(scan_c);
    assign scan_end  = (int'(scan_c) >= int'(n_reg));
    assign prev_city = wp_reg[d_reg - 1'b1];

    // Distance RAM: written by load beats, read by the prefix check and the search.
    assign ram_we    = in_fire && (op == OP_WRITE_DIST)
                       && (int'(row_city) < MAX_CITY_COUNT)
                       && (int'(col_city) < MAX_CITY_COUNT);
    assign ram_waddr = {CIDX'(row_city), CIDX'(col_city)};
    assign ram_raddr = (state_reg == S_PRE) ? {prev_reg, pre_c} : {prev_city, scan_ci};

    tbbs_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (DIST_BITS'(distance_value)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared cost unit for the prefix cost and every search extension.
    assign cu_base = (state_reg == S_PRE_ADD) ? cost_reg : pc_reg[d_reg];
    assign cu_zero = (state_reg == S_ADD) && (d_reg == '0);

    tbbs_cost_unit #(
        .DIST_BITS (DIST_BITS)
    ) u_cost (
        .base      (cu_base),
        .edge_dist (ram_rdata),
        .zero      (cu_zero),
        .bound     (best_reg),
        .res       (cu_res)
    );

    // Sequencer for loads, prefix check, depth-first search and result beats.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            city_count_reg <= CITY_COUNT_RESET;
            n_reg          <= NW'(2);
            plen_reg       <= '0;
            visited_reg    <= '0;
            best_reg       <= COST_ALL_ONES;
            cost_reg       <= '0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
            d_reg          <= '0;
            cand_reg       <= '0;
            prev_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                city_count_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (op)
                            OP_APPEND:
                            begin
                                if (int'(plen_reg) < MAX_CITY_COUNT)
                                begin
                                    prefix_reg[plen_reg[CIDX-1:0]] <= prefix_city;
                                    plen_reg <= plen_reg + 1'b1;
                                end
                            end
                            OP_START:
                            begin
                                if (start_bound < best_reg)
                                begin
                                    best_reg <= start_bound;
                                end
                                n_reg     <= n_calc;
                                idx_reg   <= '0;
                                cost_reg  <= '0;
                                found_reg <= 1'b0;
                                state_reg <= S_PRE;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_PRE:
                begin
                    if (plen_reg > n_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (idx_reg == plen_reg)
                    begin
                        if (plen_reg == n_reg)
                        begin
                            if (cost_reg < best_reg)
                            begin
                                best_reg  <= cost_reg;
                                found_reg <= 1'b1;
                                for (int k = 0; k < MAX_CITY_COUNT; k++)
                                begin
                                    best_tour_reg[k] <= wp_reg[k];
                                end
                            end
                            idx_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            d_reg                       <= CIDX'(plen_reg);
                            nc_reg[plen_reg[CIDX-1:0]]  <= '0;
                            pc_reg[plen_reg[CIDX-1:0]]  <= cost_reg;
                            state_reg                   <= S_SCAN;
                        end
                    end
                    else if (pre_bad)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        wp_reg[idx_reg[CIDX-1:0]] <= pre_c;
                        visited_reg[pre_c]        <= 1'b1;
                        prev_reg                  <= pre_c;
                        if (idx_reg == '0)
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_PRE_ADD;
                        end
                    end
                end
                S_PRE_ADD:
                begin
                    cost_reg  <= cu_res.cost;
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_PRE;
                end
                S_SCAN:
                begin
                    if (scan_end)
                    begin
                        if (int'(d_reg) == int'(plen_reg))
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            d_reg                  <= d_reg - 1'b1;
                            visited_reg[prev_city] <= 1'b0;
                        end
                    end
                    else
                    begin
                        nc_reg[d_reg] <= scan_c + 1'b1;
                        if (!visited_reg[scan_ci])
                        begin
                            cand_reg  <= scan_ci;
                            state_reg <= S_ADD;
                        end
                    end
                end
                S_ADD:
                begin
                    if (cu_res.below)
                    begin
                        wp_reg[d_reg] <= cand_reg;
                        if (int'(d_reg) + 1 == int'(n_reg))
                        begin
                            best_reg  <= cu_res.cost;
                            found_reg <= 1'b1;
                            for (int k = 0; k < MAX_CITY_COUNT; k++)
                            begin
                                best_tour_reg[k] <= (CIDX'(k) == d_reg) ? cand_reg : wp_reg[k];
                            end
                        end
                        else
                        begin
                            visited_reg[cand_reg]  <= 1'b1;
                            pc_reg[d_reg + 1'b1]   <= cu_res.cost;
                            nc_reg[d_reg + 1'b1]   <= '0;
                            d_reg                  <= d_reg + 1'b1;
                        end
                    end
                    state_reg <= S_SCAN;
                end
                S_EMIT:
                begin
                    if (out_fire)
                    begin
                        if (last)
                        begin
                            plen_reg    <= '0;
                            visited_reg <= '0;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result beat fields.
    assign found         = found_reg;
    assign tour_distance = best_reg;
    assign position      = found_reg ? 4'(idx_reg) : 4'd0;
    assign tour_city     = found_reg ? 4'(best_tour_reg[idx_reg[CIDX-1:0]]) : 4'd0;
    assign last          = !found_reg || (int'(idx_reg) + 1 == int'(n_reg));

`ifndef NO_ASSERTIONS
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (visited_reg == '0))
        else $error("visited mask not clear while idle");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> ((int'(d_reg) < int'(n_reg)) &&
                                   (int'(d_reg) >= int'(plen_reg))))
        else $error("search depth outside prefix length and city count");

    a_bound_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (best_reg <= $past(best_reg)))
        else $error("best bound increased");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last) |=> ((state_reg == S_IDLE) && (plen_reg == '0)))
        else $error("prefix not cleared after final result beat");
`endif

endmodule
